// ----- design/rtc_pkg.sv -----
// shared types, constants and rounding helper for the rigid transform composer
`timescale 1ns / 1ps

package rtc_pkg;

   localparam int QW     = 32;        // q16.16 word
   localparam int PW     = 2 * QW;    // full product, q32.32
   localparam int SW     = PW + 2;    // sum of three products plus a scaled term
   localparam int FRAC   = 16;        // fraction bits dropped when rounding
   localparam int RW     = SW - FRAC; // width after the rounding shift
   localparam int NTOOL  = 12;        // 3x4 tool matrix
   localparam int NPAIR  = NTOOL / 2; // csr registers, two entries each
   localparam int CSR_IW = 3;         // enough for the six registers

   typedef logic signed [QW-1:0] q16_type;
   typedef logic signed [SW-1:0] sum_type;
   typedef logic [NTOOL-1:0][QW-1:0] tool_type;

   typedef enum logic {
      CMD_COMPOSE = 1'b0,
      CMD_INVERSE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic    sat;
      q16_type val;
   } rsat_type;

   // one pose row as it enters the pipe
   typedef struct packed {
      cmd_type             cmd;
      logic [1:0]          row;
      logic [2:0][QW-1:0]  e;
      q16_type             e3;
   } item_type;

   // after the product stage
   typedef struct packed {
      cmd_type             cmd;
      logic [1:0]          row;
      logic [2:0][QW-1:0]  e;
      q16_type             e3;
      logic [11:0][PW-1:0] prod;   // 3c+k: rotation terms, 9+k: column 3 compose terms
      logic [8:0][PW-1:0]  dprod;  // 3k+j: tool column k times tool translation
   } p1_type;

   // after the sum stage
   typedef struct packed {
      cmd_type             cmd;
      logic [1:0]          row;
      logic [2:0][QW-1:0]  e;
      q16_type             e3;
      logic [3:0][SW-1:0]  sum;
      logic [2:0][SW-1:0]  dsum;
   } p2_type;

   // after the rounding stage
   typedef struct packed {
      cmd_type             cmd;
      logic [1:0]          row;
      logic [2:0][QW-1:0]  e;
      q16_type             e3;
      logic [3:0][QW-1:0]  res;
      logic [2:0][QW-1:0]  d;
      logic                res_sat;
      logic                col3_sat;
      logic                d_sat;
   } p3_type;

   // after the inverse translation products
   typedef struct packed {
      cmd_type             cmd;
      logic [1:0]          row;
      logic [3:0][QW-1:0]  res;
      q16_type             e3;
      logic [2:0][PW-1:0]  ed;
      logic                res_sat;
      logic                col3_sat;
      logic                d_sat;
   } p4_type;

   // finished result row
   typedef struct packed {
      logic [1:0] row;
      q16_type    x;
      q16_type    y;
      q16_type    z;
      q16_type    shift;
      logic       sat;
   } out_type;

   // round half up from q32.32 to q16.16, then clip to 32 bits
   function automatic rsat_type round_sat(input sum_type s);
      sum_type           t;
      logic [RW-1:0]     v;
      rsat_type          r;
      t = s + (sum_type'(1) <<< (FRAC - 1));
      v = t[SW-1:FRAC];
      r.sat = !((&v[RW-1:QW-1]) || !(|v[RW-1:QW-1]));
      if (r.sat) begin
         r.val = v[RW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
         r.val = v[QW-1:0];
      end
      return r;
   endfunction

endpackage

// ----- design/rtc_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps

interface rtc_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [1:0]         row_index;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic signed [31:0] pose_z;
   logic signed [31:0] pose_shift;

   modport source (output valid, cmd, row_index, pose_x, pose_y, pose_z, pose_shift,
                   input ready);
   modport sink   (input valid, cmd, row_index, pose_x, pose_y, pose_z, pose_shift,
                   output ready);
endinterface

interface rtc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         out_row;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [31:0] out_shift;
   logic               saturated;

   modport source (output valid, out_row, out_x, out_y, out_z, out_shift, saturated,
                   input ready);
   modport sink   (input valid, out_row, out_x, out_y, out_z, out_shift, saturated,
                   output ready);
endinterface

// ----- design/rigid_transform_compose_unit.sv -----
// top level of the rigid transform composer
//
//   channel    dir   handshake                payload
//   req_chan   in    valid / ready            cmd, row_index, pose_x/y/z, pose_shift
//   rsp_chan   out   valid / ready            out_row, out_x/y/z, out_shift, saturated
//   csr        in    csr_wr_en, no back-off   csr_index, csr_wdata (64 bits)
//
// one row per cycle sustained while rsp_chan is not stalled; a request passes through
// the five register stages before its result shows on rsp_chan
// (products, sums, rounding, inverse translation products, result register)
// synchronous active-high reset clears the stage valid bits and the tool registers
// each stage holds while its successor is full and stalled, so a stall on rsp_chan
// backs up stage by stage and bubbles in the pipe are squeezed out
`timescale 1ns / 1ps

module rigid_transform_compose_unit (
   input  logic                        clock,
   input  logic                        reset,
   rtc_req_if.sink                     req_chan,
   rtc_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [rtc_pkg::CSR_IW-1:0]  csr_index,
   input  logic [rtc_pkg::PW-1:0]      csr_wdata
);
   import rtc_pkg::*;

   tool_type tool;
   item_type item;
   logic     s1_valid;
   logic     s1_ready;
   p1_type   s1_data;
   logic     s3_valid;
   logic     s3_ready;
   p3_type   s3_data;
   out_type  result;

   // tool matrix T = [R | t], row-major
   rtc_tool_regs u_tool_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .tool      (tool)
   );

   // pack the request payload
   always_comb begin
      item.cmd  = cmd_type'(req_chan.cmd);
      item.row  = req_chan.row_index;
      item.e[0] = req_chan.pose_x;
      item.e[1] = req_chan.pose_y;
      item.e[2] = req_chan.pose_z;
      item.e3   = req_chan.pose_shift;
   end

   // stage 1: every product of the row with T (or its transpose) and of R^T with t
   rtc_prod_stage u_prod_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_item   (item),
      .tool      (tool),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   // stages 2 and 3: exact sums, then round half up and clip
   rtc_reduce_stage u_reduce_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   // stages 4 and 5: inverse translation, mode select, result register
   rtc_shift_stage u_shift_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (result)
   );

   // unpack the result register onto the response channel
   assign rsp_chan.out_row   = result.row;
   assign rsp_chan.out_x     = result.x;
   assign rsp_chan.out_y     = result.y;
   assign rsp_chan.out_z     = result.z;
   assign rsp_chan.out_shift = result.shift;
   assign rsp_chan.saturated = result.sat;

endmodule

// ----- design/rtc_tool_regs.sv -----
// tool transform configuration registers
`timescale 1ns / 1ps

module rtc_tool_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rtc_pkg::CSR_IW-1:0]  csr_index,
   input  logic [rtc_pkg::PW-1:0]      csr_wdata,
   output rtc_pkg::tool_type           tool
);
   import rtc_pkg::*;

   logic [NPAIR-1:0][PW-1:0] pair_ff;
   logic [NPAIR-1:0][PW-1:0] pair_in;

   always_comb begin
      pair_in = pair_ff;
      for (int p = 0; p < NPAIR; p++) begin
         if (csr_wr_en && (csr_index == CSR_IW'(p))) begin
            pair_in[p] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= '0;
      end else begin
         pair_ff <= pair_in;
      end
   end

   // entry 2p in the low half, 2p+1 in the high half
   always_comb begin
      for (int p = 0; p < NPAIR; p++) begin
         tool[2*p]   = pair_ff[p][QW-1:0];
         tool[2*p+1] = pair_ff[p][PW-1:QW];
      end
   end

endmodule

// ----- design/rtc_prod_stage.sv -----
// first pipe stage: all 32x32 products of the pose row and the tool matrix
`timescale 1ns / 1ps

module rtc_prod_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rtc_pkg::item_type  in_item,
   input  rtc_pkg::tool_type  tool,
   output logic               out_valid,
   input  logic               out_ready,
   output rtc_pkg::p1_type    out_data
);
   import rtc_pkg::*;

   logic   valid_ff;
   logic   valid_in;
   p1_type data_ff;
   p1_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      q16_type                ea;
      q16_type                tb;
      logic signed [PW-1:0]   p;
      data_in.cmd = in_item.cmd;
      data_in.row = in_item.row;
      data_in.e   = in_item.e;
      data_in.e3  = in_item.e3;
      // rotation part: row of T columns, or of T transposed when inverting
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 3; k++) begin
            ea = in_item.e[k];
            tb = (in_item.cmd == CMD_INVERSE) ? tool[4*c+k] : tool[4*k+c];
            p  = ea * tb;
            data_in.prod[3*c+k] = p;
         end
      end
      // translation column in compose mode
      for (int k = 0; k < 3; k++) begin
         ea = in_item.e[k];
         tb = tool[4*k+3];
         p  = ea * tb;
         data_in.prod[9+k] = p;
      end
      // R transposed times t, needed for the inverse translation
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            ea = tool[4*j+k];
            tb = tool[4*j+3];
            p  = ea * tb;
            data_in.dprod[3*k+j] = p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/rtc_reduce_stage.sv -----
// second and third pipe stages: sum the products, then round and clip
`timescale 1ns / 1ps

module rtc_reduce_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rtc_pkg::p1_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rtc_pkg::p3_type  out_data
);
   import rtc_pkg::*;

   logic   valid2_ff;
   logic   valid2_in;
   logic   valid3_ff;
   logic   valid3_in;
   logic   ready2;
   logic   ready3;
   p2_type data2_ff;
   p2_type data2_in;
   p3_type data3_ff;
   p3_type data3_in;

   assign ready3    = !valid3_ff || out_ready;
   assign ready2    = !valid2_ff || ready3;
   assign in_ready  = ready2;
   assign valid2_in = ready2 ? in_valid : valid2_ff;
   assign valid3_in = ready3 ? valid2_ff : valid3_ff;

   // sums
   always_comb begin
      sum_type acc;
      data2_in.cmd = in_data.cmd;
      data2_in.row = in_data.row;
      data2_in.e   = in_data.e;
      data2_in.e3  = in_data.e3;
      for (int c = 0; c < 4; c++) begin
         acc = (c == 3) ? (sum_type'($signed(in_data.e3)) <<< FRAC) : '0;
         for (int k = 0; k < 3; k++) begin
            acc = acc + sum_type'($signed(in_data.prod[3*c+k]));
         end
         data2_in.sum[c] = acc;
      end
      for (int k = 0; k < 3; k++) begin
         acc = '0;
         for (int j = 0; j < 3; j++) begin
            acc = acc + sum_type'($signed(in_data.dprod[3*k+j]));
         end
         data2_in.dsum[k] = acc;
      end
   end

   // rounding and clipping
   always_comb begin
      rsat_type r;
      data3_in.cmd      = data2_ff.cmd;
      data3_in.row      = data2_ff.row;
      data3_in.e        = data2_ff.e;
      data3_in.e3       = data2_ff.e3;
      data3_in.res_sat  = 1'b0;
      data3_in.col3_sat = 1'b0;
      data3_in.d_sat    = 1'b0;
      for (int c = 0; c < 4; c++) begin
         r = round_sat(data2_ff.sum[c]);
         data3_in.res[c] = r.val;
         if (c == 3) begin
            data3_in.col3_sat = r.sat;
         end else begin
            data3_in.res_sat = data3_in.res_sat | r.sat;
         end
      end
      for (int k = 0; k < 3; k++) begin
         r = round_sat(data2_ff.dsum[k]);
         data3_in.d[k]  = r.val;
         data3_in.d_sat = data3_in.d_sat | r.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready2) begin
         data2_ff <= data2_in;
      end
      if (valid2_ff && ready3) begin
         data3_ff <= data3_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_data  = data3_ff;

endmodule

// ----- design/rtc_shift_stage.sv -----
// fourth and fifth pipe stages: inverse translation and the result register
`timescale 1ns / 1ps

module rtc_shift_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rtc_pkg::p3_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rtc_pkg::out_type out_data
);
   import rtc_pkg::*;

   logic    valid4_ff;
   logic    valid4_in;
   logic    valid5_ff;
   logic    valid5_in;
   logic    ready4;
   logic    ready5;
   p4_type  data4_ff;
   p4_type  data4_in;
   out_type data5_ff;
   out_type data5_in;

   assign ready5    = !valid5_ff || out_ready;
   assign ready4    = !valid4_ff || ready5;
   assign in_ready  = ready4;
   assign valid4_in = ready4 ? in_valid : valid4_ff;
   assign valid5_in = ready5 ? valid4_ff : valid5_ff;

   // pose rotation row times the rounded R transposed t
   always_comb begin
      q16_type              ea;
      q16_type              db;
      logic signed [PW-1:0] p;
      data4_in.cmd      = in_data.cmd;
      data4_in.row      = in_data.row;
      data4_in.res      = in_data.res;
      data4_in.e3       = in_data.e3;
      data4_in.res_sat  = in_data.res_sat;
      data4_in.col3_sat = in_data.col3_sat;
      data4_in.d_sat    = in_data.d_sat;
      for (int k = 0; k < 3; k++) begin
         ea = in_data.e[k];
         db = in_data.d[k];
         p  = ea * db;
         data4_in.ed[k] = p;
      end
   end

   // pose translation minus that sum, rounded, then pick by mode
   always_comb begin
      sum_type  acc;
      rsat_type r;
      acc = sum_type'($signed(data4_ff.e3)) <<< FRAC;
      for (int k = 0; k < 3; k++) begin
         acc = acc - sum_type'($signed(data4_ff.ed[k]));
      end
      r = round_sat(acc);
      data5_in.row = data4_ff.row;
      data5_in.x   = data4_ff.res[0];
      data5_in.y   = data4_ff.res[1];
      data5_in.z   = data4_ff.res[2];
      if (data4_ff.cmd == CMD_INVERSE) begin
         data5_in.shift = r.val;
         data5_in.sat   = data4_ff.res_sat | data4_ff.d_sat | r.sat;
      end else begin
         data5_in.shift = data4_ff.res[3];
         data5_in.sat   = data4_ff.res_sat | data4_ff.col3_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid4_ff <= valid4_in;
         valid5_ff <= valid5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready4) begin
         data4_ff <= data4_in;
      end
      if (valid4_ff && ready5) begin
         data5_ff <= data5_in;
      end
   end

   assign out_valid = valid5_ff;
   assign out_data  = data5_ff;

endmodule
